FILE: rtl/stam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet add/merge package
// Shared widths, codes and record types of the sparse triplet adder.
// ----------------------------------------------------------------------------
package stam_pkg;

	// Field widths fixed by the port definition.
	localparam int INDEX_BITS = 6;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_W    = 7;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 2;

	// Default list depth for each of the two triplet stores.
	localparam int LIST_CAPACITY_DEF = 32;

	// Reset value of every dimension register.
	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1);

	// Command codes of an input beat.
	typedef enum logic [1:0] {
		OP_LOAD_FIRST  = 2'd0,
		OP_LOAD_SECOND = 2'd1,
		OP_MERGE       = 2'd2,
		OP_NONE        = 2'd3
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS_FIRST  = 2'd0,
		CFG_COLS_FIRST  = 2'd1,
		CFG_ROWS_SECOND = 2'd2,
		CFG_COLS_SECOND = 2'd3
	} cfg_idx_t;

	// One stored triplet.
	typedef struct packed {
		logic [INDEX_BITS-1:0]        row;
		logic [INDEX_BITS-1:0]        col;
		logic signed [VALUE_BITS-1:0] val;
	} trip_t;

	// Outcome of one merge step from the shared compare/add unit.
	typedef struct packed {
		logic                         take_a;
		logic                         take_b;
		logic                         drop;
		logic                         sat;
		logic [INDEX_BITS-1:0]        row;
		logic [INDEX_BITS-1:0]        col;
		logic signed [VALUE_BITS-1:0] val;
	} alu_res_t;

	// One result beat.
	typedef struct packed {
		logic [INDEX_BITS-1:0]        row;
		logic [INDEX_BITS-1:0]        col;
		logic signed [VALUE_BITS-1:0] val;
		logic                         entry_valid;
		logic [COUNT_W-1:0]           count;
		logic                         mism;
		logic                         ovf;
		logic                         sat;
		logic                         last;
	} res_t;

endpackage

FILE: rtl/stam_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triplet store
// Single-port-write, single-port-read memory of triplets with registered read.
// ----------------------------------------------------------------------------
module stam_store #(
	parameter int DEPTH  = stam_pkg::LIST_CAPACITY_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  stam_pkg::trip_t   wdata,
	input  logic [ADDR_W-1:0] raddr,
	output stam_pkg::trip_t   rdata
);
	import stam_pkg::*;

	trip_t mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/stam_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge step unit
// Compares the two list heads by row-major key, adds on a coinciding
// position with saturation, and reports which heads advance.
// ----------------------------------------------------------------------------
module stam_alu (
	input  stam_pkg::trip_t    a,
	input  stam_pkg::trip_t    b,
	input  logic               a_ok,
	input  logic               b_ok,
	output stam_pkg::alu_res_t res
);
	import stam_pkg::*;

	logic [2*INDEX_BITS-1:0]   key_a;
	logic [2*INDEX_BITS-1:0]   key_b;
	logic                      sel_a;
	logic                      sel_b;
	logic signed [VALUE_BITS:0] sum;
	logic                      pos_ovf;
	logic                      neg_ovf;

	assign key_a = {a.row, a.col};
	assign key_b = {b.row, b.col};

	// Pick the smaller head; equal keys take both.
	assign sel_a = !b_ok || (a_ok && (key_a < key_b));
	assign sel_b = !sel_a && (!a_ok || (key_b < key_a));

	// Widened sum and its overflow direction.
	assign sum     = {a.val[VALUE_BITS-1], a.val} + {b.val[VALUE_BITS-1], b.val};
	assign pos_ovf = !sum[VALUE_BITS] && sum[VALUE_BITS-1];
	assign neg_ovf = sum[VALUE_BITS] && !sum[VALUE_BITS-1];

	always_comb begin
		res        = '0;
		res.take_a = !sel_b;
		res.take_b = !sel_a;
		if (sel_b) begin
			res.row = b.row;
			res.col = b.col;
			res.val = b.val;
		end else begin
			res.row = a.row;
			res.col = a.col;
			res.val = a.val;
		end
		// Coinciding position: saturated sum, zero sum is dropped.
		if (!sel_a && !sel_b) begin
			res.drop = (sum == '0);
			if (pos_ovf) begin
				res.val = {1'b0, {(VALUE_BITS-1){1'b1}}};
				res.sat = 1'b1;
			end else if (neg_ovf) begin
				res.val = {1'b1, {(VALUE_BITS-1){1'b0}}};
				res.sat = 1'b1;
			end else begin
				res.val = sum[VALUE_BITS-1:0];
			end
		end
	end

endmodule

FILE: rtl/sparse_triplet_add_merge_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet add/merge top level
// Loads two row-major triplet lists and emits their saturated sum on a merge.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | opcode, entry_row, entry_col, entry_value
//  out      | out_valid / out_ready| row_out .. last_out (one result per beat)
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  A load beat is taken while idle and in_ready stays high across loads.
//  A merge reads both store heads in ST_READ and runs the shared compare/add
//  unit on them in ST_CMP for each list step; a full merge keeps in_ready low
//  until ST_FIN has put out the closing beat, and output stalls hold it longer;
//  a merge with mismatched dimensions goes straight from idle to ST_FIN.
//  One result is held back so that the final beat can be marked last.
//  in_ready is low during a merge; a stalled out_ready holds the sequencer.
//  Reset clears the counts and the overflow flag and sets the dimension
//  registers to one.
// ----------------------------------------------------------------------------
module sparse_triplet_add_merge_top #(
	parameter int LIST_CAPACITY = stam_pkg::LIST_CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input beat channel.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           opcode,
	input  logic [stam_pkg::INDEX_BITS-1:0]      entry_row,
	input  logic [stam_pkg::INDEX_BITS-1:0]      entry_col,
	input  logic signed [stam_pkg::VALUE_BITS-1:0] entry_value,
	// Result beat channel.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [stam_pkg::INDEX_BITS-1:0]      row_out,
	output logic [stam_pkg::INDEX_BITS-1:0]      col_out,
	output logic signed [stam_pkg::VALUE_BITS-1:0] value_out,
	output logic                                 entry_valid,
	output logic [stam_pkg::COUNT_W-1:0]         entries_so_far,
	output logic                                 dims_mismatch,
	output logic                                 load_overflow,
	output logic                                 sum_saturated,
	output logic                                 last_out,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [stam_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stam_pkg::CFG_W-1:0]           cfg_data
);
	import stam_pkg::*;

	localparam int ADDR_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
	localparam int CNT_W  = $clog2(LIST_CAPACITY + 1);
	localparam int K_W    = $clog2(2 * LIST_CAPACITY + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   rows_first_q;
	logic [CFG_W-1:0]   cols_first_q;
	logic [CFG_W-1:0]   rows_second_q;
	logic [CFG_W-1:0]   cols_second_q;
	logic [CNT_W-1:0]   cnt_a_q;
	logic [CNT_W-1:0]   cnt_b_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [K_W-1:0]     k_q;
	logic               ovf_q;
	logic               mism_q;
	logic               pend_valid_q;
	logic               out_valid_q;
	res_t               pend_q;
	res_t               out_q;

	logic               in_fire;
	logic               wr_a;
	logic               wr_b;
	logic               a_ok;
	logic               b_ok;
	logic               out_free;
	logic               push;
	logic               fin_go;
	logic               load_out;
	logic               dims_differ;
	res_t               out_next;
	res_t               new_res;
	trip_t              wr_trip;
	trip_t              head_a;
	trip_t              head_b;
	alu_res_t           alu;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign wr_a        = in_fire && (opcode == OP_LOAD_FIRST) &&
	                     (cnt_a_q < CNT_W'(LIST_CAPACITY));
	assign wr_b        = in_fire && (opcode == OP_LOAD_SECOND) &&
	                     (cnt_b_q < CNT_W'(LIST_CAPACITY));
	assign dims_differ = (rows_first_q != rows_second_q) ||
	                     (cols_first_q != cols_second_q);

	assign wr_trip.row = entry_row;
	assign wr_trip.col = entry_col;
	assign wr_trip.val = entry_value;

	// The two triplet stores.
	stam_store #(.DEPTH(LIST_CAPACITY), .ADDR_W(ADDR_W)) u_store_a (
		.clk   (clk),
		.we    (wr_a),
		.waddr (cnt_a_q[ADDR_W-1:0]),
		.wdata (wr_trip),
		.raddr (i_q[ADDR_W-1:0]),
		.rdata (head_a)
	);

	stam_store #(.DEPTH(LIST_CAPACITY), .ADDR_W(ADDR_W)) u_store_b (
		.clk   (clk),
		.we    (wr_b),
		.waddr (cnt_b_q[ADDR_W-1:0]),
		.wdata (wr_trip),
		.raddr (j_q[ADDR_W-1:0]),
		.rdata (head_b)
	);

	// Shared compare/add unit over the two heads.
	assign a_ok = (i_q < cnt_a_q);
	assign b_ok = (j_q < cnt_b_q);

	stam_alu u_alu (
		.a    (head_a),
		.b    (head_b),
		.a_ok (a_ok),
		.b_ok (b_ok),
		.res  (alu)
	);

	// Result beat built from the current merge step.
	always_comb begin
		new_res             = '0;
		new_res.row         = alu.row;
		new_res.col         = alu.col;
		new_res.val         = alu.val;
		new_res.entry_valid = 1'b1;
		new_res.count       = COUNT_W'(k_q + K_W'(1));
		new_res.ovf         = ovf_q;
		new_res.sat         = alu.sat;
	end

	// Output register control: a held result moves out when a newer one
	// arrives, and the held or an empty result closes the run.
	assign out_free = !out_valid_q || out_ready;
	assign push     = (state_q == ST_CMP) && (a_ok || b_ok) && !alu.drop &&
	                  (!pend_valid_q || out_free);
	assign fin_go   = (state_q == ST_FIN) && out_free;
	assign load_out = (push && pend_valid_q) || fin_go;

	always_comb begin
		out_next = pend_q;
		if (state_q == ST_FIN) begin
			if (!pend_valid_q) begin
				out_next      = '0;
				out_next.mism = mism_q;
				out_next.ovf  = ovf_q;
			end
			out_next.last = 1'b1;
		end
	end

	// Sequencer, counters and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rows_first_q  <= DIM_RESET;
			cols_first_q  <= DIM_RESET;
			rows_second_q <= DIM_RESET;
			cols_second_q <= DIM_RESET;
			cnt_a_q       <= '0;
			cnt_b_q       <= '0;
			i_q           <= '0;
			j_q           <= '0;
			k_q           <= '0;
			ovf_q         <= 1'b0;
			mism_q        <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROWS_FIRST:  rows_first_q  <= cfg_data;
					CFG_COLS_FIRST:  cols_first_q  <= cfg_data;
					CFG_ROWS_SECOND: rows_second_q <= cfg_data;
					CFG_COLS_SECOND: cols_second_q <= cfg_data;
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (opcode)
							OP_LOAD_FIRST: begin
								if (wr_a) begin
									cnt_a_q <= cnt_a_q + CNT_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_LOAD_SECOND: begin
								if (wr_b) begin
									cnt_b_q <= cnt_b_q + CNT_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_MERGE: begin
								i_q    <= '0;
								j_q    <= '0;
								k_q    <= '0;
								mism_q <= dims_differ;
								state_q <= dims_differ ? ST_FIN : ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!a_ok && !b_ok) begin
						state_q <= ST_FIN;
					end else if (alu.drop || push) begin
						i_q     <= i_q + CNT_W'(alu.take_a);
						j_q     <= j_q + CNT_W'(alu.take_b);
						state_q <= ST_READ;
						if (push) begin
							pend_valid_q <= 1'b1;
							k_q          <= k_q + K_W'(1);
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						pend_valid_q <= 1'b0;
						cnt_a_q      <= '0;
						cnt_b_q      <= '0;
						ovf_q        <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= new_res;
		end
		if (load_out) begin
			out_q <= out_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign row_out        = out_q.row;
	assign col_out        = out_q.col;
	assign value_out      = out_q.val;
	assign entry_valid    = out_q.entry_valid;
	assign entries_so_far = out_q.count;
	assign dims_mismatch  = out_q.mism;
	assign load_overflow  = out_q.ovf;
	assign sum_saturated  = out_q.sat;
	assign last_out       = out_q.last;

endmodule
